FILE: hw/rtl/hcw_pkg.sv
// Shared types, constants and arithmetic helpers for the HSV color wheel pixel core.
package hcw_pkg;

  // Configuration register map
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 1'd1;

  localparam logic [10:0] WHEEL_SIZE_RST = 11'd256;
  localparam logic [15:0] BRIGHTNESS_RST = 16'hFFFF;
  localparam logic [10:0] MAX_SIZE       = 11'd1024;

  // Pipeline section lengths
  localparam int CORDIC_STEPS = 22;
  localparam int DIV_STEPS    = 32;
  localparam int SQRT_STEPS   = 16;
  localparam int RGB_STAGES   = 6;
  localparam int PIPE_DEPTH   = 2 + CORDIC_STEPS + 1 + DIV_STEPS + SQRT_STEPS + RGB_STAGES;

  localparam logic [23:0] HALF_TURN = 24'h800000;

  // Angle rotator lane
  typedef struct packed {
    logic signed [29:0] x;
    logic signed [29:0] y;
    logic [23:0]        ang;
    logic [20:0]        d2;
  } cordic_t;

  // Values that ride along the divider and root sections
  typedef struct packed {
    logic [15:0] hue;
    logic        zero;
    logic        clamp;
  } tag_t;

  typedef struct packed {
    logic [18:0] rem;
    logic [31:0] work;
    tag_t        tag;
  } div_t;

  typedef struct packed {
    logic [17:0] rem;
    logic [31:0] work;
    logic [15:0] res;
    tag_t        tag;
  } sqrt_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb8_t;

  // atan(2^-i) in units of 2^-24 turn
  function automatic logic [23:0] atan_turn(input logic [4:0] i);
    logic [23:0] a;
    case (i)
      5'd0:  a = 24'd2097152;
      5'd1:  a = 24'd1238021;
      5'd2:  a = 24'd654136;
      5'd3:  a = 24'd332050;
      5'd4:  a = 24'd166669;
      5'd5:  a = 24'd83416;
      5'd6:  a = 24'd41718;
      5'd7:  a = 24'd20860;
      5'd8:  a = 24'd10430;
      5'd9:  a = 24'd5215;
      5'd10: a = 24'd2608;
      5'd11: a = 24'd1304;
      5'd12: a = 24'd652;
      5'd13: a = 24'd326;
      5'd14: a = 24'd163;
      5'd15: a = 24'd81;
      5'd16: a = 24'd41;
      5'd17: a = 24'd20;
      5'd18: a = 24'd10;
      5'd19: a = 24'd5;
      5'd20: a = 24'd3;
      5'd21: a = 24'd1;
      default: a = 24'd0;
    endcase
    return a;
  endfunction

  // floor(a / 65535) for a below 65536 * 65535, no divider needed
  function automatic logic [16:0] div65535(input logic [32:0] a);
    logic [33:0] t;
    t = {1'b0, a} + {17'b0, a[32:16]} + 34'd1;
    return t[32:16];
  endfunction

endpackage

FILE: hw/rtl/hcw_if.sv
// Valid/ready channel interfaces for pixel coordinates and pixel colors.
interface hcw_pix_if;
  logic       valid;
  logic       ready;
  logic [9:0] pixel_x;
  logic [9:0] pixel_y;
  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface hcw_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: hw/rtl/hcw_cordic_cell.sv
// One vectoring step of the angle rotator.
module hcw_cordic_cell (
  input  logic             clk,
  input  logic             en,
  input  logic [4:0]       step,
  input  hcw_pkg::cordic_t d,
  output hcw_pkg::cordic_t q
);
  import hcw_pkg::*;

  logic signed [29:0] xs;
  logic signed [29:0] ys;
  cordic_t            nxt;

  // rotate toward the x axis, accumulate angle
  always_comb begin
    xs = $signed(d.x) >>> step;
    ys = $signed(d.y) >>> step;
    nxt.d2 = d.d2;
    if ($signed(d.y) > 30'sd0) begin
      nxt.x   = d.x + ys;
      nxt.y   = d.y - xs;
      nxt.ang = d.ang + atan_turn(step);
    end else begin
      nxt.x   = d.x - ys;
      nxt.y   = d.y + xs;
      nxt.ang = d.ang - atan_turn(step);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end
endmodule

FILE: hw/rtl/hcw_div_cell.sv
// One restoring-division step: one quotient bit per cell.
module hcw_div_cell (
  input  logic          clk,
  input  logic          en,
  input  logic [18:0]   divisor,
  input  hcw_pkg::div_t d,
  output hcw_pkg::div_t q
);
  import hcw_pkg::*;

  logic [19:0] trial;
  logic        ge;
  logic [19:0] diff;
  div_t        nxt;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    trial    = {d.rem, d.work[31]};
    ge       = trial >= {1'b0, divisor};
    diff     = trial - {1'b0, divisor};
    nxt.rem  = ge ? diff[18:0] : trial[18:0];
    nxt.work = {d.work[30:0], ge};
    nxt.tag  = d.tag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end
endmodule

FILE: hw/rtl/hcw_sqrt_cell.sv
// One digit-by-digit square root step: one root bit per cell.
module hcw_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  hcw_pkg::sqrt_t d,
  output hcw_pkg::sqrt_t q
);
  import hcw_pkg::*;

  logic [19:0] trial;
  logic [19:0] cand;
  logic [19:0] diff;
  logic        ge;
  sqrt_t       nxt;

  // bring down two radicand bits, test (4*root + 1)
  always_comb begin
    trial    = {d.rem, d.work[31:30]};
    cand     = {2'b00, d.res, 2'b01};
    ge       = trial >= cand;
    diff     = trial - cand;
    nxt.rem  = ge ? diff[17:0] : trial[17:0];
    nxt.res  = {d.res[14:0], ge};
    nxt.work = {d.work[29:0], 2'b00};
    nxt.tag  = d.tag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end
endmodule

FILE: hw/rtl/hcw_hsv2rgb.sv
// Six-sector HSV to 8-bit RGB conversion, six pipeline stages.
module hcw_hsv2rgb (
  input  logic           clk,
  input  logic           en,
  input  logic [15:0]    value,
  input  hcw_pkg::sqrt_t d,
  output hcw_pkg::rgb8_t q
);
  import hcw_pkg::*;

  // stage A
  logic [15:0] s_a;
  logic [15:0] f_a;
  logic [2:0]  sec_a;
  // stage B
  logic [31:0] sf_b;
  logic [32:0] sg_b;
  logic [31:0] pp_b;
  logic [2:0]  sec_b;
  // stage C
  logic [15:0] kq_c;
  logic [15:0] kt_c;
  logic [15:0] p_c;
  logic [2:0]  sec_c;
  // stage D
  logic [31:0] qp_d;
  logic [31:0] tp_d;
  logic [15:0] p_d;
  logic [2:0]  sec_d;
  // stage E
  logic [15:0] r_e;
  logic [15:0] g_e;
  logic [15:0] b_e;

  logic [15:0] s_w;
  logic [18:0] h6;
  logic [32:0] sf_rnd;
  logic [33:0] sg_rnd;
  logic [16:0] p_w;
  logic [16:0] q_w;
  logic [16:0] t_w;
  logic [15:0] rr;
  logic [15:0] gg;
  logic [15:0] bb;
  logic [16:0] r8;
  logic [16:0] g8;
  logic [16:0] b8;

  // saturation select and hue sector split
  always_comb begin
    if (d.tag.zero) begin
      s_w = 16'd0;
    end else if (d.tag.clamp) begin
      s_w = 16'hFFFF;
    end else begin
      s_w = d.res;
    end
    h6 = {1'b0, d.tag.hue, 2'b00} + {2'b00, d.tag.hue, 1'b0};
  end

  // rounding of s*f terms and p
  always_comb begin
    sf_rnd = {1'b0, sf_b} + 33'd32768;
    sg_rnd = {1'b0, sg_b} + 34'd32768;
    p_w    = div65535({1'b0, pp_b} + 33'd32767);
  end

  // q, t and sector select
  always_comb begin
    q_w = div65535({1'b0, qp_d} + 33'd32767);
    t_w = div65535({1'b0, tp_d} + 33'd32767);
    case (sec_d)
      3'd0: begin rr = value;    gg = t_w[15:0]; bb = p_d;       end
      3'd1: begin rr = q_w[15:0]; gg = value;    bb = p_d;       end
      3'd2: begin rr = p_d;      gg = value;     bb = t_w[15:0]; end
      3'd3: begin rr = p_d;      gg = q_w[15:0]; bb = value;     end
      3'd4: begin rr = t_w[15:0]; gg = p_d;      bb = value;     end
      default: begin rr = value; gg = p_d;       bb = q_w[15:0]; end
    endcase
  end

  // 16-bit to 8-bit rounding: (c*255 + 32767) / 65535
  always_comb begin
    r8 = div65535(({9'b0, r_e, 8'b0} - {17'b0, r_e}) + 33'd32767);
    g8 = div65535(({9'b0, g_e, 8'b0} - {17'b0, g_e}) + 33'd32767);
    b8 = div65535(({9'b0, b_e, 8'b0} - {17'b0, b_e}) + 33'd32767);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_a   <= s_w;
      f_a   <= h6[15:0];
      sec_a <= h6[18:16];

      sf_b  <= s_a * f_a;
      sg_b  <= {17'b0, s_a} * (33'h10000 - {17'b0, f_a});
      pp_b  <= value * (16'hFFFF - s_a);
      sec_b <= sec_a;

      kq_c  <= 16'hFFFF - sf_rnd[31:16];
      kt_c  <= 16'hFFFF - sg_rnd[31:16];
      p_c   <= p_w[15:0];
      sec_c <= sec_b;

      qp_d  <= value * kq_c;
      tp_d  <= value * kt_c;
      p_d   <= p_c;
      sec_d <= sec_c;

      r_e   <= rr;
      g_e   <= gg;
      b_e   <= bb;

      q.red   <= r8[7:0];
      q.green <= g8[7:0];
      q.blue  <= b8[7:0];
    end
  end
endmodule

FILE: hw/rtl/hsv_color_wheel_pixel_core.sv
// HSV color wheel pixel core: one pixel coordinate in, one RGB color out, one per clock.
// Each request (pixel_x, pixel_y) is colored as a point of a square HSV wheel whose radius
// is wheel_size/2 (wheel_size capped at 1024); hue is the polar angle, saturation the
// distance from the center over the radius (full outside the circle), value the
// brightness register. The core is a 79-stage chain: an offset stage, a start-vector stage,
// 22 angle-rotator steps, a hue stage, 32 divider steps, 16 square-root steps and a 6-stage
// color converter. It takes one request every clock until its output buffer is full; a
// two-entry output buffer lets it keep taking requests while one finished color waits, and
// it pauses only when both buffer entries are held. Configuration is to be written through
// cfg_we/cfg_index/cfg_data only while no request is in flight; the core does not enforce it.
module hsv_color_wheel_pixel_core (
  input  logic                          clk,
  input  logic                          rst,
  hcw_pix_if.sink                       pixel,
  hcw_rgb_if.source                     color,
  input  logic                          cfg_we,
  input  logic [hcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hcw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hcw_pkg::*;

  // configuration
  logic [10:0] wheel_size;
  logic [15:0] brightness;
  logic [18:0] r2;
  logic [10:0] size_eff;
  logic [9:0]  radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_size <= WHEEL_SIZE_RST;
      brightness <= BRIGHTNESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WHEEL_SIZE: wheel_size <= cfg_data[10:0];
        REG_BRIGHTNESS: brightness <= cfg_data;
        default: ;
      endcase
    end
  end

  assign size_eff = (wheel_size > MAX_SIZE) ? MAX_SIZE : wheel_size;
  assign radius   = size_eff[10:1];

  // squared radius, stable while requests are in flight
  always_ff @(posedge clk) begin
    r2 <= {9'b0, radius} * {9'b0, radius};
  end

  // pipeline control
  logic                  en;
  logic                  push;
  logic                  pop;
  logic [PIPE_DEPTH-1:0] vld;
  logic [1:0]            cnt;

  assign en          = (cnt != 2'd2);
  assign pixel.ready = en;
  assign push        = en && vld[PIPE_DEPTH-1];
  assign pop         = color.valid && color.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], pixel.valid};
    end
  end

  // stage 0: offsets from center
  logic signed [10:0] dx;
  logic signed [10:0] dy;

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= $signed({1'b0, pixel.pixel_x} - {1'b0, radius});
      dy <= $signed({1'b0, pixel.pixel_y} - {1'b0, radius});
    end
  end

  // stage 1: squared distance and rotator start vector
  cordic_t            c [CORDIC_STEPS+1];
  logic signed [21:0] dx_sq;
  logic signed [21:0] dy_sq;
  logic signed [29:0] xe;
  logic signed [29:0] ye;

  always_comb begin
    dx_sq = dx * dx;
    dy_sq = dy * dy;
    xe    = {{3{dy[10]}}, dy, 16'b0};
    ye    = {{3{dx[10]}}, dx, 16'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c[0].d2 <= dx_sq[20:0] + dy_sq[20:0];
      if (dy < 11'sd0) begin
        c[0].x   <= -xe;
        c[0].y   <= -ye;
        c[0].ang <= HALF_TURN;
      end else begin
        c[0].x   <= xe;
        c[0].y   <= ye;
        c[0].ang <= 24'd0;
      end
    end
  end

  // angle rotator chain
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    hcw_cordic_cell u_cell (
      .clk  (clk),
      .en   (en),
      .step (5'(i)),
      .d    (c[i]),
      .q    (c[i+1])
    );
  end

  // hue rounding, saturation flags, dividend d2 * 65535^2
  div_t        dv [DIV_STEPS+1];
  logic [23:0] h24;
  logic [24:0] hsum;
  logic [52:0] num;
  logic [20:0] d2_f;

  always_comb begin
    d2_f = c[CORDIC_STEPS].d2;
    h24  = c[CORDIC_STEPS].ang + HALF_TURN;
    hsum = {1'b0, h24} + 25'd128;
    num  = {d2_f, 32'b0} - {15'b0, d2_f, 17'b0} + {32'b0, d2_f};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].tag.hue   <= hsum[23:8];
      dv[0].tag.zero  <= (d2_f == 21'd0);
      dv[0].tag.clamp <= (d2_f >= {2'b00, r2});
      dv[0].rem       <= num[50:32];
      dv[0].work      <= num[31:0];
    end
  end

  // divider chain
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    hcw_div_cell u_cell (
      .clk     (clk),
      .en      (en),
      .divisor (r2),
      .d       (dv[i]),
      .q       (dv[i+1])
    );
  end

  // square root chain
  sqrt_t sq [SQRT_STEPS+1];

  always_comb begin
    sq[0].rem  = 18'd0;
    sq[0].res  = 16'd0;
    sq[0].work = dv[DIV_STEPS].work;
    sq[0].tag  = dv[DIV_STEPS].tag;
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    hcw_sqrt_cell u_cell (
      .clk (clk),
      .en  (en),
      .d   (sq[i]),
      .q   (sq[i+1])
    );
  end

  // color conversion
  rgb8_t pix_rgb;

  hcw_hsv2rgb u_hsv2rgb (
    .clk   (clk),
    .en    (en),
    .value (brightness),
    .d     (sq[SQRT_STEPS]),
    .q     (pix_rgb)
  );

  // two-entry output buffer
  rgb8_t buf_q [2];
  logic  wr_ptr;
  logic  rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= pix_rgb;
    end
  end

  assign color.valid = (cnt != 2'd0);
  assign color.red   = buf_q[rd_ptr].red;
  assign color.green = buf_q[rd_ptr].green;
  assign color.blue  = buf_q[rd_ptr].blue;

  // input stalls only once the buffer has just filled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(pixel.ready) |-> $past(push) && !$past(pop))
    else $error("input stalled without the output buffer filling");

  // a finished color is visible the next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    push |=> color.valid)
    else $error("pushed color not presented");

  // a stalled last stage keeps its color
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    vld[PIPE_DEPTH-1] && !en |=> vld[PIPE_DEPTH-1] && $stable(pix_rgb))
    else $error("last stage lost its color during a stall");

endmodule
